>>> rtl/core/svfi_pkg.sv
// ----------------------------------------------------------------------------
// svfi_pkg
// Shared types and constants for the superframe index parser.
// ----------------------------------------------------------------------------
package svfi_pkg;

	// Tail window: the trailing bytes of a buffer that can hold a full index
	localparam int WIN_BYTES  = 34;
	localparam int WIN_W      = WIN_BYTES * 8;
	// Size bytes inside the largest index (8 frames of 4 bytes)
	localparam int SIZE_BYTES = 32;
	localparam int SIZE_W     = SIZE_BYTES * 8;

	localparam int QUEUE_DEPTH = 2;

	// Marker byte: top three bits 110
	localparam logic [7:0] MARKER_MASK = 8'he0;
	localparam logic [7:0] MARKER_TAG  = 8'hc0;
	// Index adds an opening and a closing marker byte
	localparam logic [6:0] MARKER_PAIR = 7'd2;

	// Job kinds handed from the front to the back
	localparam logic [1:0] JOB_PLAIN = 2'd0;  // no index, one frame of buffer length
	localparam logic [1:0] JOB_INDEX = 2'd1;  // valid superframe index
	localparam logic [1:0] JOB_ERROR = 2'd2;  // malformed index

	typedef struct packed {
		logic [1:0]        kind;
		logic [SIZE_W-1:0] sizes;   // size bytes in stream order, first at [7:0]
		logic [31:0]       count;   // saturated buffer length
		logic [3:0]        frames;  // 1..8
		logic [2:0]        width;   // 1..4 bytes per size
		logic [5:0]        total;   // index length in bytes
	} job_t;

endpackage

>>> rtl/core/svfi_front.sv
// ----------------------------------------------------------------------------
// svfi_front
// Byte intake: counts bytes, keeps the tail window, classifies the buffer.
// ----------------------------------------------------------------------------
module svfi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic              q_full,
	output logic              q_push,
	output svfi_pkg::job_t    q_job
);

	localparam int WIN_W = svfi_pkg::WIN_W;

	logic [WIN_W-1:0] win_q;
	logic [31:0]      count_q;

	logic [WIN_W-1:0] win_next;
	logic [31:0]      count_next;
	logic             accept;
	logic             is_marker;
	logic [3:0]       frames;
	logic [2:0]       width;
	logic [6:0]       prod;
	logic [5:0]       total;
	logic [8:0]       chk_sh;
	logic [8:0]       al_sh;
	logic [WIN_W-1:0] chk_vec;
	logic [WIN_W-1:0] al_vec;
	logic             long_enough;

	// Oldest byte at the bottom, newest at the top
	assign win_next   = {data_byte, win_q[WIN_W-1:8]};
	assign count_next = (count_q == 32'hffff_ffff) ? count_q : count_q + 32'd1;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;
	assign q_push     = accept && final_byte;

	assign is_marker = (data_byte & svfi_pkg::MARKER_MASK) == svfi_pkg::MARKER_TAG;
	assign frames    = {1'b0, data_byte[2:0]} + 4'd1;
	assign width     = {1'b0, data_byte[4:3]} + 3'd1;
	assign prod      = 7'(frames) * 7'(width);
	assign total     = 6'(prod + svfi_pkg::MARKER_PAIR);

	// Opening marker sits total bytes back; first size byte one after it
	assign chk_sh  = {6'(svfi_pkg::WIN_BYTES) - total, 3'b000};
	assign al_sh   = {6'(svfi_pkg::WIN_BYTES + 1) - total, 3'b000};
	assign chk_vec = win_next >> chk_sh;
	assign al_vec  = win_next >> al_sh;

	assign long_enough = count_next >= 32'(total);

	always_comb begin
		q_job.sizes  = al_vec[svfi_pkg::SIZE_W-1:0];
		q_job.count  = count_next;
		q_job.frames = frames;
		q_job.width  = width;
		q_job.total  = total;
		if (!is_marker) begin
			q_job.kind = svfi_pkg::JOB_PLAIN;
		end else if (long_enough && (chk_vec[7:0] == data_byte)) begin
			q_job.kind = svfi_pkg::JOB_INDEX;
		end else begin
			q_job.kind = svfi_pkg::JOB_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				win_q   <= '0;
				count_q <= '0;
			end else begin
				win_q   <= win_next;
				count_q <= count_next;
			end
		end
	end

endmodule

>>> rtl/core/svfi_queue.sv
// ----------------------------------------------------------------------------
// svfi_queue
// Short job queue between the intake and the result sequencer.
// ----------------------------------------------------------------------------
module svfi_queue #(
	parameter int DEPTH = svfi_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  svfi_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output svfi_pkg::job_t pop_job,
	output logic           empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	svfi_pkg::job_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  fill_q;
	logic           do_push;
	logic           do_pop;

	assign full    = fill_q == CW'(DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("queue fill beyond depth");

endmodule

>>> rtl/core/svfi_back.sv
// ----------------------------------------------------------------------------
// svfi_back
// Result sequencer: turns one job into its result transactions.
// ----------------------------------------------------------------------------
module svfi_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  svfi_pkg::job_t q_job,
	output logic           q_pop,
	output logic           result_valid,
	input  logic           result_ready,
	output logic [31:0]    frame_size,
	output logic [3:0]     buffer_frames,
	output logic [5:0]     index_bytes,
	output logic           status,
	output logic           last_result
);

	localparam int SIZE_W = svfi_pkg::SIZE_W;

	logic              result_valid_q;
	logic              active_q;
	logic [3:0]        rem_q;
	logic [SIZE_W-1:0] sizes_q;
	logic [2:0]        width_q;
	logic [3:0]        frames_q;
	logic [5:0]        total_q;
	logic [31:0]       size_q;
	logic [3:0]        count_q;
	logic [5:0]        idx_q;
	logic              status_q;
	logic              last_q;

	logic              can_load;
	logic [31:0]       cur_size;

	assign can_load = !result_valid_q || result_ready;
	assign q_pop    = can_load && !active_q && !q_empty;

	// Little-endian size of width_q bytes at the bottom of the buffer
	always_comb begin
		case (width_q)
			3'd1:    cur_size = {24'd0, sizes_q[7:0]};
			3'd2:    cur_size = {16'd0, sizes_q[15:0]};
			3'd3:    cur_size = {8'd0, sizes_q[23:0]};
			default: cur_size = sizes_q[31:0];
		endcase
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			active_q       <= 1'b0;
			rem_q          <= '0;
		end else if (can_load) begin
			if (active_q) begin
				result_valid_q <= 1'b1;
				rem_q          <= rem_q - 4'd1;
				active_q       <= rem_q != 4'd1;
			end else if (q_pop) begin
				case (q_job.kind)
					svfi_pkg::JOB_INDEX: begin
						result_valid_q <= 1'b0;
						active_q       <= 1'b1;
						rem_q          <= q_job.frames;
					end
					default: begin
						result_valid_q <= 1'b1;
					end
				endcase
			end else begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (can_load) begin
			if (active_q) begin
				size_q   <= cur_size;
				count_q  <= frames_q;
				idx_q    <= total_q;
				status_q <= 1'b0;
				last_q   <= rem_q == 4'd1;
				sizes_q  <= sizes_q >> {width_q, 3'b000};
			end else if (q_pop) begin
				case (q_job.kind)
					svfi_pkg::JOB_INDEX: begin
						sizes_q  <= q_job.sizes;
						width_q  <= q_job.width;
						frames_q <= q_job.frames;
						total_q  <= q_job.total;
					end
					svfi_pkg::JOB_PLAIN: begin
						size_q   <= q_job.count;
						count_q  <= 4'd1;
						idx_q    <= '0;
						status_q <= 1'b0;
						last_q   <= 1'b1;
					end
					default: begin
						size_q   <= '0;
						count_q  <= '0;
						idx_q    <= '0;
						status_q <= 1'b1;
						last_q   <= 1'b1;
					end
				endcase
			end
		end
	end

	assign result_valid  = result_valid_q;
	assign frame_size    = size_q;
	assign buffer_frames = count_q;
	assign index_bytes   = idx_q;
	assign status        = status_q;
	assign last_result   = last_q;

	a_active_rem: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (rem_q != 4'd0))
		else $error("emitting with no frames left");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !q_pop)
		else $error("job taken while index still emitting");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && status_q) |-> (last_q && (count_q == 4'd0) && (size_q == 32'd0)))
		else $error("malformed result not a single empty transaction");

endmodule

>>> rtl/core/vp9_superframe_index_parser.sv
// ----------------------------------------------------------------------------
// vp9_superframe_index_parser
// Superframe index parser for compressed VP9 buffers.
// ----------------------------------------------------------------------------
// Bytes of one buffer enter one per cycle, with final_byte set on the last
// one. The intake counts bytes (saturating at 2^32-1) and holds the trailing
// 34 bytes; on the final byte it decodes the marker, checks the index length
// against the byte count and the opening marker, and pushes one job into a
// short queue (QUEUE_DEPTH entries). The sequencer then produces the results:
// one transaction per contained frame for a valid index, otherwise a single
// transaction (buffer length for no index, status 1 for a malformed one).
// Intake rate is one byte per cycle; it stalls only when the queue is full.
// The sequencer loads an index job, then emits one result per frame; a job
// without an index is loaded and emitted together, so the sequencer keeps
// up with the intake while result_ready is high, since every buffer with an
// index is at least n + 2 bytes long. Results sit in an output register, so
// the intake keeps running while a result waits for result_ready, until the queue fills.
// ----------------------------------------------------------------------------
module vp9_superframe_index_parser #(
	parameter int QUEUE_DEPTH = svfi_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] frame_size,
	output logic [3:0]  buffer_frames,
	output logic [5:0]  index_bytes,
	output logic        status,
	output logic        last_result
);

	svfi_pkg::job_t push_job;
	svfi_pkg::job_t pop_job;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;

	// Intake: window, byte count, classification at buffer end
	svfi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	// Decouple intake from result emission
	svfi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// Emit result transactions, at most one per cycle; result_ready low holds them
	svfi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (pop_job),
		.q_pop         (q_pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.frame_size    (frame_size),
		.buffer_frames (buffer_frames),
		.index_bytes   (index_bytes),
		.status        (status),
		.last_result   (last_result)
	);

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the superframe index parser.
// ----------------------------------------------------------------------------
// Feeds whole buffers byte by byte (plain buffers, buffers that close with a
// superframe index, and malformed or truncated indexes). A behavioral model
// in this file predicts the frame records of each buffer. Every result
// transaction is compared field by field against the oldest predicted record.
// Both handshakes idle at random, with one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int   WIN_BYTES        = svfi_pkg::WIN_BYTES;
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_MALFORMED = 1'b1;
	localparam int   IDLE_PERCENT     = 26;
	localparam int   RANDOM_BYTES     = 456;
	localparam int   DRAIN_LIMIT      = 2000;
	localparam int   SETTLE_CYCLES    = 40;

	typedef enum int {
		KIND_INDEX,
		KIND_PLAIN,
		KIND_SHORT,
		KIND_BAD_OPEN,
		KIND_NOISE
	} buffer_kind_t;

	// One predicted frame record, in the order the block reports them
	typedef struct packed {
		logic [31:0] fsize;
		logic [3:0]  fcount;
		logic [5:0]  ibytes;
		logic        stat;
		logic        last;
	} frame_rec_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  data_byte;
	logic        final_byte;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] frame_size;
	logic [3:0]  buffer_frames;
	logic [5:0]  index_bytes;
	logic        status;
	logic        last_result;

	// Model state: trailing bytes (newest at the top entry) and the fill count
	logic [7:0]  tail_bytes [WIN_BYTES];
	logic [31:0] fill_count;

	frame_rec_t  expected_frames [$];
	logic [7:0]  pending_bytes [$];

	bit          no_gaps;
	int          errors;
	int          bytes_sent;
	int          buffers_sent;
	int          results_seen;
	int          index_buffers;

	vp9_superframe_index_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.data_byte     (data_byte),
		.final_byte    (final_byte),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.frame_size    (frame_size),
		.buffer_frames (buffer_frames),
		.index_bytes   (index_bytes),
		.status        (status),
		.last_result   (last_result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Model: shift one accepted byte into the window; on the final byte decode
	// the trailing marker and queue the frame records the buffer produces.
	// ------------------------------------------------------------------------
	task automatic predict_frames(input logic [7:0] b, input logic fin);
		logic [7:0]  marker;
		logic [31:0] sz;
		int          n;
		int          w;
		int          total;
		int          pos;
		frame_rec_t  rec;
		for (int i = 0; i < WIN_BYTES - 1; i++)
			tail_bytes[i] = tail_bytes[i + 1];
		tail_bytes[WIN_BYTES - 1] = b;
		// Hold the count at its ceiling rather than wrap
		if (fill_count != 32'hFFFF_FFFF)
			fill_count++;
		if (!fin)
			return;

		marker = tail_bytes[WIN_BYTES - 1];
		if ((marker & svfi_pkg::MARKER_MASK) == svfi_pkg::MARKER_TAG) begin
			n = int'(marker[2:0]) + 1;
			w = int'(marker[4:3]) + 1;
			total = int'(svfi_pkg::MARKER_PAIR) + n * w;
			// Index must fit in the buffer and open with the same marker
			if (fill_count >= 32'(total) &&
					tail_bytes[WIN_BYTES - total] == marker) begin
				pos = total - 1;
				for (int i = 0; i < n; i++) begin
					sz = '0;
					// Sizes are little-endian, first frame nearest the opener
					for (int j = 0; j < w; j++) begin
						sz |= 32'(tail_bytes[WIN_BYTES - pos]) << (8 * j);
						pos--;
					end
					rec.fsize  = sz;
					rec.fcount = 4'(n);
					rec.ibytes = 6'(total);
					rec.stat   = STATUS_OK;
					rec.last   = (i == n - 1);
					expected_frames.push_back(rec);
				end
			end else begin
				rec = '{fsize: '0, fcount: '0, ibytes: '0,
					stat: STATUS_MALFORMED, last: 1'b1};
				expected_frames.push_back(rec);
			end
		end else begin
			// No index: the whole buffer is one frame
			rec = '{fsize: fill_count, fcount: 4'd1, ibytes: '0,
				stat: STATUS_OK, last: 1'b1};
			expected_frames.push_back(rec);
		end

		// Close the buffer; the next byte opens a new one
		fill_count = '0;
		for (int i = 0; i < WIN_BYTES; i++)
			tail_bytes[i] = '0;
	endtask

	// ------------------------------------------------------------------------
	// Byte channel: optional idle cycles, then present the byte and hold it
	// until the transaction completes. Returns on the accepting edge.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		bytes_sent++;
		predict_frames(b, fin);
	endtask

	// Send the staged bytes as one buffer, flagging the last one
	task automatic send_buffer();
		int last_i;
		last_i = pending_bytes.size() - 1;
		for (int i = 0; i <= last_i; i++)
			send_byte(pending_bytes[i], i == last_i);
		pending_bytes.delete();
		buffers_sent++;
	endtask

	// Stage a buffer that closes with an index of n sizes, w bytes each.
	// With bad_open set, the opening marker differs from the closing one.
	task automatic stage_index(input int n, input int w, input int prefix_len,
			input logic bad_open);
		logic [7:0]  marker;
		logic [31:0] sz;
		marker = {svfi_pkg::MARKER_TAG[7:5], 2'(w - 1), 3'(n - 1)};
		repeat (prefix_len)
			pending_bytes.push_back(8'($urandom));
		if (bad_open)
			pending_bytes.push_back(marker ^ (8'h01 << $urandom_range(0, 7)));
		else
			pending_bytes.push_back(marker);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: begin
					sz = '0;
				end
				1: begin
					sz = '1;
				end
				default: begin
					sz = $urandom;
				end
			endcase
			for (int j = 0; j < w; j++)
				pending_bytes.push_back(sz[8 * j +: 8]);
		end
		pending_bytes.push_back(marker);
	endtask

	// ------------------------------------------------------------------------
	// Result channel: compare each transaction with the oldest prediction,
	// then pick the ready level for the next cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		frame_rec_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_frames.size() == 0) begin
					$error("result with nothing predicted: frame_size %0h buffer_frames %0d",
						frame_size, buffer_frames);
					errors++;
				end else begin
					want = expected_frames.pop_front();
					if (frame_size !== want.fsize) begin
						$error("frame_size: expected %0h, got %0h", want.fsize, frame_size);
						errors++;
					end
					if (buffer_frames !== want.fcount) begin
						$error("buffer_frames: expected %0d, got %0d",
							want.fcount, buffer_frames);
						errors++;
					end
					if (index_bytes !== want.ibytes) begin
						$error("index_bytes: expected %0d, got %0d", want.ibytes, index_bytes);
						errors++;
					end
					if (status !== want.stat) begin
						$error("status: expected %0d, got %0d", want.stat, status);
						errors++;
					end
					if (last_result !== want.last) begin
						$error("last_result: expected %0d, got %0d", want.last, last_result);
						errors++;
					end
				end
			end
			result_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Buffers whose last byte is no marker: one frame of the buffer length
	task automatic test_plain_buffers();
		pending_bytes = '{8'h00};
		send_buffer();
		pending_bytes = '{8'hff};
		send_buffer();
		pending_bytes = '{8'h12, 8'h34, 8'he0};
		send_buffer();
	endtask

	// Exact-length indexes: smallest size width, widest size at all ones,
	// and two frames of two bytes with a zero size
	task automatic test_superframe_index();
		pending_bytes = '{8'hc0, 8'h05, 8'hc0};
		send_buffer();
		pending_bytes = '{8'hd8, 8'hff, 8'hff, 8'hff, 8'hff, 8'hd8};
		send_buffer();
		pending_bytes = '{8'hc9, 8'h00, 8'h00, 8'h34, 8'h12, 8'hc9};
		send_buffer();
		index_buffers += 3;
	endtask

	// Marker with a buffer too short for its index, and a mismatched opener
	task automatic test_malformed_index();
		pending_bytes = '{8'hc0};
		send_buffer();
		pending_bytes = '{8'hc1, 8'h05, 8'hc0};
		send_buffer();
	endtask

	// Mostly well-formed indexes with random content, plus plain buffers,
	// truncated and broken indexes, and random noise
	task automatic test_random_stream();
		buffer_kind_t kind;
		int           pick;
		int           prefix_len;
		int           start_bytes;
		int           count;
		int           drop;
		start_bytes = bytes_sent;
		count = 0;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			// Run a stretch of buffers back to back on both sides
			no_gaps = (count >= 15 && count < 25);
			pick = $urandom_range(0, 99);
			kind = pick < 55 ? KIND_INDEX :
				pick < 70 ? KIND_PLAIN :
				pick < 80 ? KIND_SHORT :
				pick < 90 ? KIND_BAD_OPEN : KIND_NOISE;

			// Mostly short payloads; some exactly fill the index, a few spill
			// well past the trailing window
			pick = $urandom_range(0, 15);
			prefix_len = pick < 5 ? 0 :
				pick == 15 ? $urandom_range(WIN_BYTES + 1, WIN_BYTES + 11) :
				$urandom_range(1, 12);

			case (kind)
				KIND_INDEX: begin
					stage_index($urandom_range(1, 8), $urandom_range(1, 4), prefix_len, 1'b0);
					index_buffers++;
				end
				KIND_PLAIN: begin
					repeat ($urandom_range(1, 16))
						pending_bytes.push_back(8'($urandom));
					// Steer the last byte off the marker pattern
					if ((pending_bytes[$] & svfi_pkg::MARKER_MASK) == svfi_pkg::MARKER_TAG)
						pending_bytes[$] = pending_bytes[$] | 8'h20;
				end
				KIND_SHORT: begin
					// Drop leading bytes so the buffer is shorter than its index
					stage_index($urandom_range(1, 8), $urandom_range(1, 4), 0, 1'b0);
					drop = $urandom_range(1, pending_bytes.size() - 1);
					repeat (drop)
						void'(pending_bytes.pop_front());
				end
				KIND_BAD_OPEN: begin
					stage_index($urandom_range(1, 8), $urandom_range(1, 4), prefix_len, 1'b1);
				end
				default: begin
					repeat ($urandom_range(1, 10))
						pending_bytes.push_back(8'($urandom));
					if ($urandom_range(0, 1) == 1)
						pending_bytes[$] = {svfi_pkg::MARKER_TAG[7:5], 5'($urandom)};
				end
			endcase
			send_buffer();
			count++;
		end
		no_gaps = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		int waited;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		data_byte    = '0;
		final_byte   = 1'b0;
		no_gaps      = 1'b0;
		errors       = 0;
		bytes_sent   = 0;
		buffers_sent = 0;
		results_seen = 0;
		index_buffers = 0;
		fill_count   = '0;
		for (int i = 0; i < WIN_BYTES; i++)
			tail_bytes[i] = '0;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_buffers();
		test_superframe_index();
		test_malformed_index();
		test_random_stream();

		// Release the byte channel and let the results drain
		byte_valid <= 1'b0;
		waited = 0;
		while (expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		// Watch a while longer for stray results
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (expected_frames.size() != 0) begin
			$error("%0d predicted frame records never arrived", expected_frames.size());
			errors++;
		end

		$display("Sent %0d buffers (%0d bytes, %0d with a well-formed index).",
			buffers_sent, bytes_sent, index_buffers);
		$display("Checked %0d results over plain, indexed, truncated, bad-opener and %s",
			results_seen, "noise buffers under random stalls.");
		if (errors == 0) begin
			$display("vp9_superframe_index_parser: match");
		end else begin
			$display("vp9_superframe_index_parser: mismatch");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure
	initial begin
		#2_000_000;
		$display("vp9_superframe_index_parser: mismatch");
		$finish;
	end

endmodule

>>> vp9_superframe_index_parser.f
rtl/core/svfi_pkg.sv
rtl/core/svfi_front.sv
rtl/core/svfi_queue.sv
rtl/core/svfi_back.sv
rtl/core/vp9_superframe_index_parser.sv
bench/tb_top.sv
